/* rtl/cdbrc_pkg.sv */
// Package for the COPY data block row counter.
// Item and result types, status and register codes, phase encoding.
// No dependencies.
`default_nettype none

package cdbrc_pkg;

	localparam int COUNT_BITS = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [7:0] DATA_BLOCK_TYPE = 8'h01;
	localparam logic [7:0] CHR_NL    = 8'h0A;
	localparam logic [7:0] CHR_BSL   = 8'h5C;
	localparam logic [7:0] CHR_DOT   = 8'h2E;

	localparam logic [CFG_IDX_W-1:0] CFG_INT_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_SIGN = 1'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE = 2'd1;
	localparam logic [1:0] ST_NEG_LEN = 2'd2;

	localparam logic [1:0] MK_NONE  = 2'd0;
	localparam logic [1:0] MK_BSL   = 2'd1;
	localparam logic [1:0] MK_DOT   = 2'd2;

	typedef enum logic [4:0] {
		PH_TYPE = 5'b00001,
		PH_ID   = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_PAY  = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_t;

	typedef struct packed {
		logic [31:0] row_count;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		logic clr;
		logic en;
	} scan_ctl_t;

endpackage

`default_nettype wire

/* rtl/cdbrc_line_scan.sv */
// Line scanner: counts newline-ended lines up to a backslash-dot line.
// Depends on cdbrc_pkg.
`default_nettype none

module cdbrc_line_scan (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cdbrc_pkg::scan_ctl_t            ctl,
	input  wire logic [7:0]                      data_byte,
	output logic      [cdbrc_pkg::COUNT_BITS-1:0] count
);

	logic [cdbrc_pkg::COUNT_BITS-1:0] cnt_q;
	logic       line_start_q;
	logic [1:0] mark_q;
	logic       term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			line_start_q <= 1'b1;
			mark_q       <= cdbrc_pkg::MK_NONE;
			term_q       <= 1'b0;
		end else if (ctl.clr) begin
			cnt_q        <= '0;
			line_start_q <= 1'b1;
			mark_q       <= cdbrc_pkg::MK_NONE;
			term_q       <= 1'b0;
		end else if (ctl.en && !term_q) begin
			if (data_byte == cdbrc_pkg::CHR_NL) begin
				if (mark_q == cdbrc_pkg::MK_DOT) begin
					term_q <= 1'b1;
				end else begin
					if (cnt_q != '1)
						cnt_q <= cnt_q + 1'b1;
					line_start_q <= 1'b1;
					mark_q       <= cdbrc_pkg::MK_NONE;
				end
			end else if (line_start_q && data_byte == cdbrc_pkg::CHR_BSL) begin
				mark_q       <= cdbrc_pkg::MK_BSL;
				line_start_q <= 1'b0;
			end else if (mark_q == cdbrc_pkg::MK_BSL && data_byte == cdbrc_pkg::CHR_DOT) begin
				mark_q <= cdbrc_pkg::MK_DOT;
			end else begin
				mark_q       <= cdbrc_pkg::MK_NONE;
				line_start_q <= 1'b0;
			end
		end
	end

	assign count = cnt_q;

endmodule

`default_nettype wire

/* rtl/copy_data_block_row_counter.sv */
// COPY data block row counter: top level.
// Depends on cdbrc_pkg and cdbrc_line_scan.
//
// Usage: raw bytes of one uncompressed data entry arrive on the item
// channel (item_valid/item_ready/item), one byte per item, first_byte set
// on the type byte of each entry. The block parses type byte, id integer
// and length-prefixed blocks, counting COPY rows in the payload.
// At the zero-length block, or on a bad type byte or negative length,
// one result leaves on the result channel (result_valid/result_ready).
// Bytes after a result are dropped until the next first_byte.
// Path: an item is held in the input register; its result is formed
// from it combinationally and then held in the result register.
// Throughput: one item per cycle unless a second result meets a
// stalled receiver; the parse step between the registers is combinational.
// A stalled receiver holds the result register; items that give no result
// keep flowing, and the block stalls only when a second result is ready.
// Configuration (cfg_valid/cfg_index/cfg_data) is always ready; write only
// while idle. Reset (arst_n low) clears the parse state, int_size to 4,
// has_sign_byte to 1, and empties both registers.
`default_nettype none

module copy_data_block_row_counter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire cdbrc_pkg::in_t                      item,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output cdbrc_pkg::out_t                          result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cdbrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cdbrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int WW = (cdbrc_pkg::COUNT_BITS > 32) ? cdbrc_pkg::COUNT_BITS : 32;

	logic [2:0] int_size_q;
	logic       has_sign_q;

	cdbrc_pkg::in_t    item_s1;
	logic              valid_s1;
	cdbrc_pkg::phase_t phase_q, phase_n;
	logic [2:0]        pos_q, pos_n;
	logic              sign_q, sign_n;
	logic [31:0]       val_q, val_n;
	logic [31:0]       left_q, left_n;

	cdbrc_pkg::out_t   res_n;
	logic              emit;
	logic              adv;
	logic              out_free;

	cdbrc_pkg::scan_ctl_t              scan_ctl;
	logic [cdbrc_pkg::COUNT_BITS-1:0]  count;
	logic [WW-1:0]                     count_w;

	// integer assembly
	cdbrc_pkg::phase_t ph_e;
	logic [2:0]  pos_e;
	logic        sign_e;
	logic [31:0] val_e;
	logic [2:0]  n_eff;
	logic [2:0]  k;
	logic [2:0]  ipos;
	logic        isign;
	logic [31:0] ival;
	logic        idone;
	logic [7:0]  b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_size_q <= 3'd4;
			has_sign_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cdbrc_pkg::CFG_INT_SIZE: int_size_q <= cfg_data;
				cdbrc_pkg::CFG_HAS_SIGN: has_sign_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free   = !result_valid || result_ready;
	assign adv        = valid_s1 && (!emit || out_free);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	assign b = item_s1.data_byte;

	always_comb begin
		ph_e   = item_s1.first_byte ? cdbrc_pkg::PH_TYPE : phase_q;
		pos_e  = item_s1.first_byte ? 3'd0 : pos_q;
		sign_e = item_s1.first_byte ? 1'b0 : sign_q;
		val_e  = item_s1.first_byte ? 32'd0 : val_q;

		if (int_size_q == 3'd0)
			n_eff = 3'd1;
		else if (int_size_q > 3'd4)
			n_eff = 3'd4;
		else
			n_eff = int_size_q;

		k     = 3'd0;
		ipos  = pos_e;
		isign = sign_e;
		ival  = val_e;
		idone = 1'b0;
		if (has_sign_q && pos_e == 3'd0) begin
			isign = (b != 8'd0);
			ipos  = 3'd1;
		end else begin
			k     = (pos_e == 3'd0) ? 3'd0 : pos_e - {2'b00, has_sign_q};
			ival  = val_e | (32'(b) << {k[1:0], 3'b000});
			ipos  = (pos_e < 3'd7) ? pos_e + 3'd1 : pos_e;
			idone = ({1'b0, k} + 4'd1) >= {1'b0, n_eff};
		end
	end

	assign count_w = WW'(count);

	always_comb begin
		phase_n = ph_e;
		pos_n   = pos_e;
		sign_n  = sign_e;
		val_n   = val_e;
		left_n  = left_q;
		emit    = 1'b0;
		res_n   = '{row_count: 32'd0, status: cdbrc_pkg::ST_OK};
		scan_ctl.clr = adv && item_s1.first_byte;
		scan_ctl.en  = 1'b0;
		case (ph_e)
			cdbrc_pkg::PH_TYPE: begin
				if (b != cdbrc_pkg::DATA_BLOCK_TYPE) begin
					emit         = 1'b1;
					res_n.status = cdbrc_pkg::ST_BAD_TYPE;
					phase_n      = cdbrc_pkg::PH_DONE;
				end else begin
					phase_n = cdbrc_pkg::PH_ID;
					pos_n   = 3'd0;
					sign_n  = 1'b0;
					val_n   = 32'd0;
				end
			end
			cdbrc_pkg::PH_ID: begin
				pos_n  = ipos;
				sign_n = isign;
				val_n  = ival;
				if (idone) begin
					phase_n = cdbrc_pkg::PH_LEN;
					pos_n   = 3'd0;
					sign_n  = 1'b0;
					val_n   = 32'd0;
				end
			end
			cdbrc_pkg::PH_LEN: begin
				pos_n  = ipos;
				sign_n = isign;
				val_n  = ival;
				if (idone) begin
					if (ival == 32'd0) begin
						emit    = 1'b1;
						phase_n = cdbrc_pkg::PH_DONE;
						res_n.row_count = (count_w > WW'(32'hFFFF_FFFF)) ?
							32'hFFFF_FFFF : count_w[31:0];
					end else if (isign) begin
						emit         = 1'b1;
						phase_n      = cdbrc_pkg::PH_DONE;
						res_n.status = cdbrc_pkg::ST_NEG_LEN;
					end else begin
						left_n  = ival;
						phase_n = cdbrc_pkg::PH_PAY;
					end
				end
			end
			cdbrc_pkg::PH_PAY: begin
				scan_ctl.en = adv;
				left_n      = left_q - 32'd1;
				if (left_n == 32'd0) begin
					phase_n = cdbrc_pkg::PH_LEN;
					pos_n   = 3'd0;
					sign_n  = 1'b0;
					val_n   = 32'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cdbrc_pkg::PH_TYPE;
			pos_q   <= 3'd0;
			sign_q  <= 1'b0;
			val_q   <= 32'd0;
			left_q  <= 32'd0;
		end else if (adv) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			sign_q  <= sign_n;
			val_q   <= val_n;
			left_q  <= left_n;
		end
	end

	cdbrc_line_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.data_byte (b),
		.count     (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv && emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			result <= res_n;
	end

endmodule

`default_nettype wire

/* rtl/cdbrc_chk.sv */
// Port checker for the COPY data block row counter, bound to the top level.
// Depends on cdbrc_pkg and copy_data_block_row_counter.
`default_nettype none

module cdbrc_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             item_ready,
	input wire logic                             result_valid,
	input wire logic                             result_ready,
	input wire cdbrc_pkg::out_t                  result
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status == cdbrc_pkg::ST_OK ||
			result.status == cdbrc_pkg::ST_BAD_TYPE ||
			result.status == cdbrc_pkg::ST_NEG_LEN)
		else $error("undefined status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != cdbrc_pkg::ST_OK |-> result.row_count == 32'd0)
		else $error("error result carries a row count");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item stalled with result register empty");

endmodule

bind copy_data_block_row_counter cdbrc_chk u_cdbrc_chk (.*);

`default_nettype wire
